[rtl/core/prru_pkg.sv]
`timescale 1ns / 1ps

package prru_pkg;

    localparam int MAX_N_DEF = 20;
    localparam int LEN_W     = 5;
    localparam int RANK_W    = 62;
    localparam int ELEM_W    = 5;

    typedef enum logic
    {
        CMD_UNRANK = 1'b0,
        CMD_RANK   = 1'b1
    } cmd_t;

    // Factorial table, 0! through 20!.
    function automatic logic [RANK_W-1:0] fact_f(input logic [LEN_W-1:0] k);
        logic [RANK_W-1:0] f;
        unique case (k)
            5'd0:    f = 62'd1;
            5'd1:    f = 62'd1;
            5'd2:    f = 62'd2;
            5'd3:    f = 62'd6;
            5'd4:    f = 62'd24;
            5'd5:    f = 62'd120;
            5'd6:    f = 62'd720;
            5'd7:    f = 62'd5040;
            5'd8:    f = 62'd40320;
            5'd9:    f = 62'd362880;
            5'd10:   f = 62'd3628800;
            5'd11:   f = 62'd39916800;
            5'd12:   f = 62'd479001600;
            5'd13:   f = 62'd6227020800;
            5'd14:   f = 62'd87178291200;
            5'd15:   f = 62'd1307674368000;
            5'd16:   f = 62'd20922789888000;
            5'd17:   f = 62'd355687428096000;
            5'd18:   f = 62'd6402373705728000;
            5'd19:   f = 62'd121645100408832000;
            5'd20:   f = 62'd2432902008176640000;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

[rtl/core/prru_if.sv]
`timescale 1ns / 1ps

interface prru_req_if
    import prru_pkg::*;
();
    logic              valid;
    logic              ready;
    cmd_t              command;
    logic [LEN_W-1:0]  length;
    logic [RANK_W-1:0] rank_in;
    logic [ELEM_W-1:0] value_in;

    modport source (output valid, command, length, rank_in, value_in, input ready);
    modport sink   (input valid, command, length, rank_in, value_in, output ready);
endinterface

interface prru_rsp_if
    import prru_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ELEM_W-1:0] element;
    logic [RANK_W-1:0] rank_out;
    logic              last;
    logic              error;

    modport source (output valid, element, rank_out, last, error, input ready);
    modport sink   (input valid, element, rank_out, last, error, output ready);
endinterface

[rtl/core/permutation_rank_unrank_unit.sv]
`timescale 1ns / 1ps

// Lexicographic permutation rank/unrank through the factorial number system.
// A command 0 item (length n, 1-based rank) yields the n elements of that
// permutation, the last one marked; a bad length or a rank of 0 or above n!
// yields one error result. Command 1 items carry one element each; a bad first
// length gives an error result, else the n-th item yields the 1-based rank,
// with error set if any element was out of range or repeated. Everything runs
// through one 62-bit add/subtract unit, one step per cycle while the output is
// free: an unrank checks the range, then for each element scans the candidates
// up to the pick (at most n each); a rank item scans the elements below its
// value v, then steps the position, and the final item adds one. The input is
// ready only between items, while a finished result may wait in the output register.
module permutation_rank_unrank_unit
    import prru_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    prru_req_if.sink    req,
    prru_rsp_if.source  rsp
);

    localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_UN_CHECK,
        S_UN_SCAN,
        S_RK_SCAN,
        S_RK_POS,
        S_RK_FINAL,
        S_ERR
    } state_t;

    state_t            state_reg, state_next;
    logic [RANK_W-1:0] r_reg, r_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [MAX_N-1:0]  taken_reg, taken_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  tgt_reg, tgt_next;
    logic [MAX_N-1:0]  used_reg, used_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  saved_len_reg, saved_len_next;
    logic [RANK_W-1:0] rank_sum_reg, rank_sum_next;
    logic              err_seen_reg, err_seen_next;

    logic              out_valid_reg, out_valid_next;
    logic [ELEM_W-1:0] element_reg, element_next;
    logic [RANK_W-1:0] rank_out_reg, rank_out_next;
    logic              last_reg, last_next;
    logic              error_reg, error_next;

    // Shared add/subtract unit.
    logic [RANK_W-1:0] op_a, op_b;
    logic              op_sub;
    logic [RANK_W:0]   op_res;
    logic              borrow;

    logic              accept;
    logic              out_free;
    logic              len_ok;
    logic [LEN_W-1:0]  n_eff;
    logic [ELEM_W-1:0] dec_v;
    logic              elem_ok;
    logic [LEN_W-1:0]  pos_inc;

    assign req.ready    = (state_reg == S_IDLE);
    assign accept       = req.valid && req.ready;
    assign out_free     = !out_valid_reg || rsp.ready;

    assign rsp.valid    = out_valid_reg;
    assign rsp.element  = element_reg;
    assign rsp.rank_out = rank_out_reg;
    assign rsp.last     = last_reg;
    assign rsp.error    = error_reg;

    assign op_res = op_sub ? ({1'b0, op_a} - {1'b0, op_b}) : ({1'b0, op_a} + {1'b0, op_b});
    assign borrow = op_res[RANK_W];

    assign len_ok  = (req.length != '0) && (req.length <= LEN_W'(MAX_N));
    assign n_eff   = (pos_reg == '0) ? req.length : saved_len_reg;
    assign dec_v   = req.value_in - ELEM_W'(1);
    assign elem_ok = (req.value_in != '0) && (req.value_in <= n_eff)
                     && !used_reg[dec_v[IDX_W-1:0]];
    assign pos_inc = pos_reg + LEN_W'(1);

    always_comb
    begin
        unique case (state_reg)
            S_UN_SCAN:
            begin
                op_a   = r_reg;
                op_b   = fact_f(rem_reg - LEN_W'(1));
                op_sub = 1'b1;
            end
            S_RK_SCAN:
            begin
                op_a   = rank_sum_reg;
                op_b   = fact_f(saved_len_reg - pos_reg - LEN_W'(1));
                op_sub = 1'b0;
            end
            S_RK_FINAL:
            begin
                op_a   = rank_sum_reg;
                op_b   = RANK_W'(1);
                op_sub = 1'b0;
            end
            default:
            begin
                op_a   = r_reg;
                op_b   = fact_f(len_reg);
                op_sub = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        len_next       = len_reg;
        rem_next       = rem_reg;
        taken_next     = taken_reg;
        idx_next       = idx_reg;
        tgt_next       = tgt_reg;
        used_next      = used_reg;
        pos_next       = pos_reg;
        saved_len_next = saved_len_reg;
        rank_sum_next  = rank_sum_reg;
        err_seen_next  = err_seen_reg;

        out_valid_next = out_valid_reg && !rsp.ready;
        element_next   = element_reg;
        rank_out_next  = rank_out_reg;
        last_next      = last_reg;
        error_next     = error_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.command == CMD_UNRANK)
                    begin
                        if (!len_ok)
                        begin
                            state_next = S_ERR;
                        end
                        else
                        begin
                            // A rank of zero wraps to all ones and fails the range check.
                            r_next     = req.rank_in - RANK_W'(1);
                            len_next   = req.length;
                            state_next = S_UN_CHECK;
                        end
                    end
                    else if (pos_reg == '0 && !len_ok)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        saved_len_next = n_eff;
                        idx_next       = '0;
                        tgt_next       = dec_v[IDX_W-1:0];
                        if (elem_ok)
                        begin
                            state_next = S_RK_SCAN;
                        end
                        else
                        begin
                            err_seen_next = 1'b1;
                            state_next    = S_RK_POS;
                        end
                    end
                end
            end

            S_UN_CHECK:
            begin
                if (!borrow)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    rem_next   = len_reg;
                    idx_next   = '0;
                    taken_next = '0;
                    state_next = S_UN_SCAN;
                end
            end

            S_UN_SCAN:
            begin
                // Walk the free elements, peeling one factorial block off the
                // remaining rank for each one skipped.
                if (taken_reg[idx_reg])
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                else if (!borrow)
                begin
                    r_next   = op_res[RANK_W-1:0];
                    idx_next = idx_reg + IDX_W'(1);
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    element_next   = ELEM_W'(idx_reg) + ELEM_W'(1);
                    rank_out_next  = '0;
                    last_next      = (rem_reg == LEN_W'(1));
                    error_next     = 1'b0;
                    taken_next     = taken_reg | (MAX_N'(1) << idx_reg);
                    rem_next       = rem_reg - LEN_W'(1);
                    idx_next       = '0;
                    if (rem_reg == LEN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_RK_SCAN:
            begin
                // Each unused element below the new one adds one factorial block.
                if (idx_reg == tgt_reg)
                begin
                    used_next  = used_reg | (MAX_N'(1) << tgt_reg);
                    state_next = S_RK_POS;
                end
                else
                begin
                    if (!used_reg[idx_reg])
                    begin
                        rank_sum_next = op_res[RANK_W-1:0];
                    end
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            S_RK_POS:
            begin
                pos_next = pos_inc;
                if (pos_inc >= saved_len_reg)
                begin
                    state_next = S_RK_FINAL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_RK_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    element_next   = '0;
                    rank_out_next  = op_res[RANK_W-1:0];
                    last_next      = 1'b1;
                    error_next     = err_seen_reg;
                    used_next      = '0;
                    pos_next       = '0;
                    saved_len_next = '0;
                    rank_sum_next  = '0;
                    err_seen_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    element_next   = '0;
                    rank_out_next  = '0;
                    last_next      = 1'b1;
                    error_next     = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            pos_reg       <= '0;
            saved_len_reg <= '0;
            rank_sum_reg  <= '0;
            err_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            pos_reg       <= pos_next;
            saved_len_reg <= saved_len_next;
            rank_sum_reg  <= rank_sum_next;
            err_seen_reg  <= err_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg        <= r_next;
        len_reg      <= len_next;
        rem_reg      <= rem_next;
        taken_reg    <= taken_next;
        idx_reg      <= idx_next;
        tgt_reg      <= tgt_next;
        element_reg  <= element_next;
        rank_out_reg <= rank_out_next;
        last_reg     <= last_next;
        error_reg    <= error_next;
    end

endmodule

[rtl/core/prru_chk.sv]
`timescale 1ns / 1ps

module prru_chk
    import prru_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [ELEM_W-1:0] element,
    input logic [RANK_W-1:0] rank_out,
    input logic              last,
    input logic              error
);

    // Error results are always final and carry no element.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && error |-> last && element == '0)
        else $error("error result without last or with an element");

    // Unranked elements never carry a rank or an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && element != '0 |-> rank_out == '0 && !error)
        else $error("element result carries a rank or an error");

    // Only unrank elements may be non-final.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> element != '0)
        else $error("non-final result without an element");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(element) && $stable(rank_out))
        else $error("stalled result changed");

endmodule

bind permutation_rank_unrank_unit prru_chk prru_chk_i
(
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .element   (rsp.element),
    .rank_out  (rsp.rank_out),
    .last      (rsp.last),
    .error     (rsp.error)
);

[tb/tb_permutation_rank_unrank_unit.sv]
`timescale 1ns / 1ps

module tb_permutation_rank_unrank_unit;
    import prru_pkg::*;

    localparam int MAX_LEN     = MAX_N_DEF;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 420;

    typedef struct packed
    {
        logic [ELEM_W-1:0] element;
        logic [RANK_W-1:0] rank;
        logic              last;
        logic              error;
    } perm_result_t;

    function automatic longint unsigned fact_of(input int k);
        longint unsigned f;
        int i;
        f = 1;
        for (i = 2; i <= k; i++)
        begin
            f = f * longint'(i);
        end
        return f;
    endfunction

    class perm_scoreboard;
        perm_result_t      expected_q[$];
        logic [19:0]       seen_mask;
        logic [4:0]        slot;
        logic [4:0]        perm_len;
        logic [RANK_W-1:0] partial_rank;
        bit                bad_seen;
        int                mismatches;
        int                strays;

        function new();
            restart();
            mismatches = 0;
            strays = 0;
        endfunction

        function void restart();
            seen_mask = '0;
            slot = '0;
            perm_len = '0;
            partial_rank = '0;
            bad_seen = 1'b0;
        endfunction

        function void push(input logic [ELEM_W-1:0] e, input logic [RANK_W-1:0] r,
                           input logic l, input logic er);
            perm_result_t res;
            res.element = e;
            res.rank = r;
            res.last = l;
            res.error = er;
            expected_q.push_back(res);
        endfunction

        // Walks the factorial digits of rank-1, picking the idx-th unused element each time.
        function void expand_rank(input logic [LEN_W-1:0] n, input logic [RANK_W-1:0] rnk);
            longint unsigned rest;
            longint unsigned blk;
            longint unsigned idx;
            logic [19:0]     taken;
            logic [4:0]      pick;
            int              rem;
            int              v;
            if (n == 0 || n > MAX_LEN || rnk == 0 || 64'(rnk) > fact_of(int'(n)))
            begin
                push('0, '0, 1'b1, 1'b1);
                return;
            end
            rest = 64'(rnk) - 1;
            taken = '0;
            for (rem = int'(n); rem >= 1; rem--)
            begin
                blk = fact_of(rem - 1);
                idx = rest / blk;
                rest = rest % blk;
                pick = '0;
                for (v = 1; v <= int'(n); v++)
                begin
                    if (!taken[v-1])
                    begin
                        if (idx == 0)
                        begin
                            pick = 5'(v);
                            break;
                        end
                        idx--;
                    end
                end
                if (pick != 0)
                    taken[pick-1] = 1'b1;
                push(pick, '0, rem == 1, 1'b0);
            end
        endfunction

        function void fold_element(input logic [LEN_W-1:0] len, input logic [ELEM_W-1:0] v);
            logic [19:0]     below;
            int              smaller;
            longint unsigned term;
            if (slot == 0)
            begin
                if (len == 0 || len > MAX_LEN)
                begin
                    restart();
                    push('0, '0, 1'b1, 1'b1);
                    return;
                end
                perm_len = len;
            end
            if (v >= 1 && v <= perm_len && !seen_mask[v-1])
            begin
                below = (20'd1 << (v - 1)) - 20'd1;
                smaller = int'(v) - 1 - $countones(seen_mask & below);
                term = longint'(smaller) * fact_of(int'(perm_len) - int'(slot) - 1);
                partial_rank = partial_rank + term[RANK_W-1:0];
                seen_mask[v-1] = 1'b1;
            end
            else
            begin
                bad_seen = 1'b1;
            end
            slot = slot + 5'd1;
            if (slot >= perm_len)
            begin
                push('0, partial_rank + 62'd1, 1'b1, bad_seen);
                restart();
            end
        endfunction

        function void note_item(input cmd_t c, input logic [LEN_W-1:0] len,
                                input logic [RANK_W-1:0] rnk, input logic [ELEM_W-1:0] v);
            if (c == CMD_UNRANK)
                expand_rank(len, rnk);
            else
                fold_element(len, v);
        endfunction

        function void check_result(input logic [ELEM_W-1:0] e, input logic [RANK_W-1:0] r,
                                   input logic l, input logic er);
            perm_result_t want;
            if (expected_q.size() == 0)
            begin
                strays++;
                if (mismatches + strays <= 10)
                    $display("unexpected result: element=%0d rank=%0d last=%0d error=%0d",
                             e, r, l, er);
                return;
            end
            want = expected_q.pop_front();
            if (want.element !== e || want.rank !== r || want.last !== l || want.error !== er)
            begin
                mismatches++;
                if (mismatches + strays <= 10)
                    $display({"mismatch: expected element=%0d rank=%0d last=%0d error=%0d,",
                              " got element=%0d rank=%0d last=%0d error=%0d"},
                             want.element, want.rank, want.last, want.error, e, r, l, er);
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function int failures();
            return mismatches + strays + expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    prru_req_if req_ch();
    prru_rsp_if rsp_ch();

    permutation_rank_unrank_unit uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    perm_scoreboard sb;
    int items_sent;
    int burst_left;
    bit squeeze;
    bit squeezed;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_item(req_ch.command, req_ch.length, req_ch.rank_in, req_ch.value_in);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.element, rsp_ch.rank_out, rsp_ch.last, rsp_ch.error);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_permutation_rank_unrank_unit failed");
                $finish;
            end
        end
    end

    // Receiver: open stretches, short stalls, random or alternating dithering, plus one long hold.
    initial
    begin : receiver
        int mode;
        int span;
        int i;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (squeeze && !squeezed)
            begin
                squeezed = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 40);
            for (i = 0; i < span; i++)
            begin
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= (i < 8) ? 1'b0 : 1'b1;
                    2: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default: rsp_ch.ready <= i[0];
                endcase
                @(negedge clk);
            end
        end
    end

    function automatic logic [RANK_W-1:0] rand62();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[RANK_W-1:0];
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 6);
        else if (r < 95)
            return $urandom_range(7, 12);
        return $urandom_range(13, MAX_LEN);
    endfunction

    // Called at a falling edge; returns on a later falling edge once the item is taken.
    task automatic send_item(input cmd_t c, input logic [LEN_W-1:0] len,
                             input logic [RANK_W-1:0] rnk, input logic [ELEM_W-1:0] v);
        req_ch.valid <= 1'b1;
        req_ch.command <= c;
        req_ch.length <= len;
        req_ch.rank_in <= rnk;
        req_ch.value_in <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        items_sent++;
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic random_unrank();
        int n;
        int sel;
        logic [RANK_W-1:0] rk;
        n = pick_len();
        sel = $urandom_range(0, 99);
        if (sel < 80)
            rk = RANK_W'((64'(rand62()) % fact_of(n)) + 1);
        else if (sel < 88)
            rk = $urandom_range(0, 1) ? 62'd1 : RANK_W'(fact_of(n));
        else if (sel < 96)
        begin
            case ($urandom_range(0, 2))
                0: rk = '0;
                1: rk = RANK_W'(fact_of(n) + $urandom_range(1, 5));
                default: rk = rand62();
            endcase
        end
        else
        begin
            n = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_LEN + 1, 31);
            rk = rand62();
        end
        send_item(CMD_UNRANK, 5'(n), rk, 5'($urandom));
    endtask

    // One whole ranking of length n, sometimes with a bad element or an unrank in the middle.
    task automatic random_ranking(input int n);
        int order[20];
        int k;
        int j;
        int tmp;
        int bad_pos;
        int mid_pos;
        logic [ELEM_W-1:0] v;
        logic [LEN_W-1:0] len;
        for (k = 0; k < n; k++)
            order[k] = k + 1;
        for (k = n - 1; k > 0; k--)
        begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        bad_pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
        mid_pos = (n > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, n - 1) : -1;
        for (k = 0; k < n; k++)
        begin
            if (k == mid_pos)
                random_unrank();
            v = 5'(order[k]);
            if (k == bad_pos)
            begin
                case ($urandom_range(0, 2))
                    0: v = '0;
                    1: v = 5'($urandom_range(n + 1, 31));
                    default: v = (k > 0) ? 5'(order[$urandom_range(0, k - 1)]) : 5'd0;
                endcase
            end
            len = (k == 0) ? 5'(n) : 5'($urandom);
            send_item(CMD_RANK, len, rand62(), v);
        end
    endtask

    initial
    begin : stimulus
        int kind;
        int wait_cycles;
        sb = new();
        items_sent = 0;
        burst_left = 0;
        squeeze = 1'b0;
        squeezed = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.command = CMD_UNRANK;
        req_ch.length = '0;
        req_ch.rank_in = '0;
        req_ch.value_in = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Unrank corners: smallest, largest and out-of-range ranks, rank zero, bad lengths.
        send_item(CMD_UNRANK, 5'd1, 62'd1, 5'd31);
        send_item(CMD_UNRANK, 5'd1, 62'd2, 5'd0);
        send_item(CMD_UNRANK, 5'd20, 62'd1, 5'd7);
        send_item(CMD_UNRANK, 5'd20, RANK_W'(fact_of(20)), 5'd3);
        send_item(CMD_UNRANK, 5'd20, RANK_W'(fact_of(20) + 1), 5'd1);
        send_item(CMD_UNRANK, 5'd5, 62'd0, 5'd2);
        send_item(CMD_UNRANK, 5'd0, 62'd1, 5'd4);
        send_item(CMD_UNRANK, 5'd21, 62'd1, 5'd4);
        send_item(CMD_UNRANK, 5'd31, {RANK_W{1'b1}}, 5'd16);
        send_item(CMD_UNRANK, 5'd3, 62'd4, 5'd8);

        // Ranking corners: length one, bad lengths, a repeat with an unrank in between,
        // and elements out of range on both sides.
        send_item(CMD_RANK, 5'd1, rand62(), 5'd1);
        send_item(CMD_RANK, 5'd0, rand62(), 5'd3);
        send_item(CMD_RANK, 5'd31, rand62(), 5'd1);
        send_item(CMD_RANK, 5'd3, rand62(), 5'd2);
        send_item(CMD_UNRANK, 5'd2, 62'd2, 5'd9);
        send_item(CMD_RANK, 5'd17, rand62(), 5'd2);
        send_item(CMD_RANK, 5'd0, rand62(), 5'd1);
        send_item(CMD_RANK, 5'd2, rand62(), 5'd0);
        send_item(CMD_RANK, 5'd2, rand62(), 5'd31);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= 80)
                squeeze = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 40)
                random_unrank();
            else if (kind < 88)
                random_ranking(pick_len());
            else
                send_item(CMD_RANK, $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(21, 31)),
                          rand62(), 5'($urandom));
        end
        req_ch.valid <= 1'b0;

        wait_cycles = 0;
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
            wait_cycles++;
            if (wait_cycles >= DRAIN_LIMIT)
            begin
                $display("tb_permutation_rank_unrank_unit failed");
                $finish;
            end
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.failures() == 0)
        begin
            $display("tb_permutation_rank_unrank_unit passed");
        end
        else
        begin
            if (sb.outstanding() != 0)
                $display("%0d expected results never arrived", sb.outstanding());
            $display("tb_permutation_rank_unrank_unit failed");
        end
        $finish;
    end

endmodule
